// ===== design/plst_pkg.sv =====
// ----------------------------------------------------------------------------
// plst_pkg
// types, constants and codes shared by the positional list store
// ----------------------------------------------------------------------------
package plst_pkg;

  localparam int CAPACITY  = 16;
  localparam int WORD_BITS = 32;

  localparam int FUNC_W   = 3;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 5;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CMP_W    = ((POS_W > COUNT_W) ? POS_W : COUNT_W) + 1;

  typedef enum logic [FUNC_W-1:0] {
    FN_INS_FRONT = 3'd0,
    FN_INS_BACK  = 3'd1,
    FN_INS_AT    = 3'd2,
    FN_DEL_FRONT = 3'd3,
    FN_DEL_BACK  = 3'd4,
    FN_DEL_AT    = 3'd5,
    FN_READ_AT   = 3'd6
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef struct packed {
    logic             load;
    op_t              op;
    logic [IDX_W-1:0] idx;
    status_t          status;
  } dp_cmd_t;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [COUNT_W-1:0] count;
  } dp_stat_t;

endpackage

// ===== design/plst_req_if.sv =====
// ----------------------------------------------------------------------------
// plst_req_if
// request channel: function code, word and position
// ----------------------------------------------------------------------------
interface plst_req_if
  import plst_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [DATA_W-1:0] value;
  logic [POS_W-1:0]         position;

  modport source (output valid, func, value, position, input ready);
  modport sink   (input valid, func, value, position, output ready);
endinterface

// ===== design/plst_rsp_if.sv =====
// ----------------------------------------------------------------------------
// plst_rsp_if
// response channel: status, element total and read word
// ----------------------------------------------------------------------------
interface plst_rsp_if
  import plst_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [TOTAL_W-1:0]       element_total;
  logic signed [DATA_W-1:0] read_value;

  modport source (output valid, status, element_total, read_value, input ready);
  modport sink   (input valid, status, element_total, read_value, output ready);
endinterface

// ===== design/plst_ctrl.sv =====
// ----------------------------------------------------------------------------
// plst_ctrl
// controller: checks each request against the count, issues the datapath
// command and tracks the held response
// ----------------------------------------------------------------------------
module plst_ctrl
  import plst_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [FUNC_W-1:0] req_func,
  input  logic [POS_W-1:0]  req_position,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  dp_stat_t          stat,
  output dp_cmd_t           cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_HOLD = 2'b10
  } state_t;

  state_t state, state_next;
  logic   accept;

  logic [CMP_W-1:0]   pos_c;
  logic [CMP_W-1:0]   cnt_c;
  logic [POS_W-1:0]   pos_m1;
  logic [COUNT_W-1:0] cnt_m1;
  logic               ins_pos_ok;
  logic               del_pos_ok;

  assign req_ready = (state == S_IDLE) || rsp_ready;
  assign rsp_valid = (state == S_HOLD);
  assign accept    = req_valid && req_ready;

  assign pos_c      = CMP_W'(req_position);
  assign cnt_c      = CMP_W'(stat.count);
  assign pos_m1     = req_position - POS_W'(1);
  assign cnt_m1     = stat.count - COUNT_W'(1);
  assign ins_pos_ok = (pos_c != '0) && (pos_c <= cnt_c + CMP_W'(1));
  assign del_pos_ok = (pos_c != '0) && (pos_c <= cnt_c);

  always_comb begin
    cmd        = '0;
    cmd.load   = accept;
    cmd.op     = OP_NONE;
    cmd.status = ST_OK;
    case (func_t'(req_func))
      FN_INS_FRONT, FN_INS_BACK, FN_INS_AT: begin
        if (stat.full) begin
          cmd.status = ST_FULL;
        end else if (req_func == FN_INS_FRONT) begin
          cmd.op  = OP_INSERT;
          cmd.idx = '0;
        end else if (req_func == FN_INS_BACK) begin
          cmd.op  = OP_INSERT;
          cmd.idx = stat.count[IDX_W-1:0];
        end else if (!ins_pos_ok) begin
          cmd.status = ST_BADPOS;
        end else begin
          cmd.op  = OP_INSERT;
          cmd.idx = pos_m1[IDX_W-1:0];
        end
      end
      FN_DEL_FRONT, FN_DEL_BACK, FN_DEL_AT, FN_READ_AT: begin
        if (stat.empty) begin
          cmd.status = ST_EMPTY;
        end else if (req_func == FN_DEL_FRONT) begin
          cmd.op  = OP_DELETE;
          cmd.idx = '0;
        end else if (req_func == FN_DEL_BACK) begin
          cmd.op  = OP_DELETE;
          cmd.idx = cnt_m1[IDX_W-1:0];
        end else if (!del_pos_ok) begin
          cmd.status = ST_BADPOS;
        end else if (req_func == FN_DEL_AT) begin
          cmd.op  = OP_DELETE;
          cmd.idx = pos_m1[IDX_W-1:0];
        end else begin
          cmd.op  = OP_READ;
          cmd.idx = pos_m1[IDX_W-1:0];
        end
      end
      default: begin
        cmd.op = OP_NONE;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_HOLD;
      end
      S_HOLD: begin
        if (rsp_ready && !accept) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/plst_dpath.sv =====
// ----------------------------------------------------------------------------
// plst_dpath
// datapath: row of word cells that shift up or down in parallel, the count
// and the response register
// ----------------------------------------------------------------------------
module plst_dpath
  import plst_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  dp_cmd_t                  cmd,
  input  logic signed [DATA_W-1:0] req_value,
  output dp_stat_t                 stat,
  output logic [STATUS_W-1:0]      rsp_status,
  output logic [TOTAL_W-1:0]       rsp_element_total,
  output logic signed [DATA_W-1:0] rsp_read_value
);

  logic [WORD_BITS-1:0] cells      [CAPACITY];
  logic [WORD_BITS-1:0] cells_next [CAPACITY];
  logic [WORD_BITS-1:0] cell_below [CAPACITY];
  logic [WORD_BITS-1:0] cell_above [CAPACITY];
  logic [COUNT_W-1:0]   count, count_next;
  logic [DATA_W-1:0]    value_u;
  logic [WORD_BITS-1:0] word_in;
  logic [DATA_W-1:0]    read_word;

  assign value_u = req_value;
  assign word_in = WORD_BITS'(value_u);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_nbr
    if (i == 0) begin : g_first
      assign cell_below[i] = cells[i];
    end else begin : g_below
      assign cell_below[i] = cells[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign cell_above[i] = cells[i];
    end else begin : g_above
      assign cell_above[i] = cells[i+1];
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_next[i] = cells[i];
      case (cmd.op)
        OP_INSERT: begin
          if (IDX_W'(i) == cmd.idx) cells_next[i] = word_in;
          else if (IDX_W'(i) > cmd.idx) cells_next[i] = cell_below[i];
        end
        OP_DELETE: begin
          if (IDX_W'(i) >= cmd.idx) cells_next[i] = cell_above[i];
        end
        default: cells_next[i] = cells[i];
      endcase
    end
  end

  always_comb begin
    case (cmd.op)
      OP_INSERT: count_next = count + COUNT_W'(1);
      OP_DELETE: count_next = count - COUNT_W'(1);
      default:   count_next = count;
    endcase
  end

  assign read_word  = DATA_W'($signed(cells[cmd.idx]));
  assign stat.count = count;
  assign stat.full  = (count == COUNT_W'(CAPACITY));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cells             <= cells_next;
      rsp_status        <= cmd.status;
      rsp_element_total <= TOTAL_W'(count_next);
      rsp_read_value    <= (cmd.op == OP_READ) ? signed'(read_word) : '0;
    end
  end

endmodule

// ===== design/positional_list_store.sv =====
// ----------------------------------------------------------------------------
// positional_list_store
// ordered list of signed words with insert, delete and read at a position
// ----------------------------------------------------------------------------
// the response is registered and valid in the cycle after the request transfer
// throughput: one request per cycle while the response side takes each result
// the count check and the parallel cell shift finish in the transfer cycle
// reset clears the element count and drops the held response; cell contents
// and response fields stay undefined until written
// ----------------------------------------------------------------------------
module positional_list_store
  import plst_pkg::*;
(
  input logic       clk,
  input logic       rst,
  plst_req_if.sink  req,
  plst_rsp_if.source rsp
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  plst_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_func     (req.func),
    .req_position (req.position),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  plst_dpath u_dpath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .req_value         (req.value),
    .stat              (stat),
    .rsp_status        (rsp.status),
    .rsp_element_total (rsp.element_total),
    .rsp_read_value    (rsp.read_value)
  );

endmodule

// ===== design/plst_checker.sv =====
// ----------------------------------------------------------------------------
// plst_checker
// port-level checks on the positional list store
// ----------------------------------------------------------------------------
module plst_checker
  import plst_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     req_valid,
  input logic                     req_ready,
  input logic                     rsp_valid,
  input logic                     rsp_ready,
  input logic [STATUS_W-1:0]      rsp_status,
  input logic [TOTAL_W-1:0]       rsp_element_total,
  input logic signed [DATA_W-1:0] rsp_read_value
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> rsp_valid)
    else $error("no response after request transfer");

  a_total_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_element_total <= TOTAL_W'(CAPACITY))
    else $error("element total above capacity");

  a_full_total: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_FULL |-> rsp_element_total == TOTAL_W'(CAPACITY))
    else $error("full status with room left");

  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_read_value == '0)
    else $error("read word on failed request");

endmodule

bind positional_list_store plst_checker u_plst_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_element_total (rsp.element_total),
  .rsp_read_value    (rsp.read_value)
);
